// ===== design/fsd_pkg.sv =====
package fsd_pkg;

    // Field widths of the stream items and the configuration registers.
    localparam int GAP_W   = 17;
    localparam int ANG_W   = 18;
    localparam int LIMIT_W = 16;

    // Working width: holds every intermediate sum of three gaps and the limit exactly.
    localparam int CALC_W  = 22;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 72;

    // Configuration register indexes.
    localparam logic [0:0] REG_SPREAD_LIMIT = 1'b0;
    localparam logic [0:0] REG_LEGACY_MODE  = 1'b1;

    localparam logic [LIMIT_W-1:0] SPREAD_LIMIT_RESET = 16'd6400;

    typedef logic signed [CALC_W-1:0] calc_t;

    // The four abduction angles at working width.
    typedef struct packed {
        calc_t little;
        calc_t ring;
        calc_t middle;
        calc_t index;
    } angles_t;

    // Negative readings count as zero spread.
    function automatic calc_t gap_clip(input logic signed [GAP_W-1:0] g);
        calc_t r;
        r = '0;
        if (!g[GAP_W-1])
        begin
            r = calc_t'({{(CALC_W-GAP_W){1'b0}}, g});
        end
        return r;
    endfunction

    // Floor of half, as an arithmetic shift.
    function automatic calc_t half_floor(input calc_t v);
        return v >>> 1;
    endfunction

    // Clamp to the symmetric range from -l to +l.
    function automatic calc_t clamp_lim(input calc_t v, input calc_t l);
        calc_t r;
        r = v;
        if (v > l)
        begin
            r = l;
        end
        else if (v < -l)
        begin
            r = -l;
        end
        return r;
    endfunction

    function automatic calc_t min_c(input calc_t x, input calc_t y);
        return (x < y) ? x : y;
    endfunction

    function automatic calc_t max_c(input calc_t x, input calc_t y);
        return (x > y) ? x : y;
    endfunction

endpackage

// ===== design/fsd_legacy.sv =====
module fsd_legacy
    import fsd_pkg::*;
(
    input  calc_t   gap_a,
    input  calc_t   gap_b,
    input  calc_t   gap_c,
    input  calc_t   limit,
    output angles_t angles
);

    calc_t half_sum;
    calc_t sum_ab;
    calc_t ix;
    calc_t md;
    calc_t rg;
    calc_t lt;

    // Half the total spread marks the centre of the hand.
    assign half_sum = half_floor(gap_a + gap_b + gap_c);
    assign sum_ab   = gap_a + gap_b;

    // Build the chain outward from the gap that holds the centre.
    always_comb
    begin
        ix = '0;
        md = '0;
        rg = '0;
        lt = '0;
        if (half_sum < gap_a)
        begin
            ix = clamp_lim(-half_sum, limit);
            md = clamp_lim(gap_a - half_sum, limit);
            rg = clamp_lim(gap_b + md, limit);
            lt = clamp_lim(gap_c + rg, limit);
        end
        else if (half_sum < sum_ab)
        begin
            md = clamp_lim(gap_a - half_sum, limit);
            ix = clamp_lim(md - gap_a, limit);
            rg = clamp_lim(gap_b + md, limit);
            lt = clamp_lim(gap_c + rg, limit);
        end
        else
        begin
            lt = clamp_lim(half_sum, limit);
            rg = clamp_lim(lt - gap_c, limit);
            md = clamp_lim(rg - gap_b, limit);
            ix = clamp_lim(md - gap_a, limit);
        end
    end

    assign angles.index  = ix;
    assign angles.middle = md;
    assign angles.ring   = rg;
    assign angles.little = lt;

endmodule

// ===== design/fsd_distribute.sv =====
module fsd_distribute
    import fsd_pkg::*;
(
    input  calc_t   gap_a,
    input  calc_t   gap_b,
    input  calc_t   gap_c,
    input  calc_t   limit,
    output angles_t angles
);

    calc_t half_b;
    calc_t ix;
    calc_t md;
    calc_t rg;
    calc_t lt;

    assign half_b = half_floor(gap_b);

    // Symmetric split when both ends fit, else saturate the end with more demand.
    always_comb
    begin
        ix = '0;
        md = '0;
        rg = '0;
        lt = '0;
        if ((half_b + gap_a <= limit) && (half_b + gap_c <= limit))
        begin
            ix = -gap_a - half_b;
            md = -half_b;
            rg = half_b;
            lt = gap_c + half_b;
        end
        else if (gap_a > gap_c)
        begin
            ix = -limit;
            lt = min_c(limit, gap_a - limit + gap_b + gap_c);
            rg = min_c(lt, half_floor((ix + gap_a + gap_b) + (lt - gap_c)));
            md = min_c(lt, half_floor((ix + gap_a) + (lt - gap_c - gap_b)));
        end
        else
        begin
            lt = limit;
            ix = max_c(-limit, limit - gap_c - gap_b - gap_a);
            md = max_c(ix, half_floor((lt - gap_c - gap_b) + (ix + gap_a)));
            rg = max_c(ix, half_floor((lt - gap_c) + (ix + gap_a + gap_b)));
        end
    end

    assign angles.index  = ix;
    assign angles.middle = md;
    assign angles.ring   = rg;
    assign angles.little = lt;

endmodule

// ===== design/finger_spread_distributor_core.sv =====
// Finger spread distributor: turns three finger-gap spread readings (signed Q8
// degrees, negatives treated as zero) into four abduction angles for index,
// middle, ring and little finger. Legacy mode finds the gap holding the centre
// and chains the angles outward, each clamped to the spread limit; the default
// mode splits the spread symmetrically or saturates the end with more demand.
// An item passes through an input register and an output register. Its result
// is presented on the output once it moves from the input register into the
// output register; a stall on the output side holds it back. One item is taken
// every cycle as long as the output side keeps up. Write the configuration only
// while no items are in flight.
module finger_spread_distributor_core
    import fsd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // index_middle_gap, middle_ring_gap, ring_little_gap, zero padding
    input  logic [IN_DATA_W-1:0]  s_tdata,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // index_angle, middle_angle, ring_angle, little_angle
    output logic [OUT_DATA_W-1:0] m_tdata,

    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [LIMIT_W-1:0]    cfg_data
);

    logic [LIMIT_W-1:0]    spread_limit_reg;
    logic                  legacy_mode_reg;

    logic                  in_valid_reg;
    logic [GAP_W-1:0]      gap_im_reg;
    logic [GAP_W-1:0]      gap_mr_reg;
    logic [GAP_W-1:0]      gap_rl_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    logic                  out_advance;
    logic                  in_advance;

    calc_t                 gap_a;
    calc_t                 gap_b;
    calc_t                 gap_c;
    calc_t                 limit;
    angles_t               legacy_angles;
    angles_t               dist_angles;
    angles_t               sel_angles;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spread_limit_reg <= SPREAD_LIMIT_RESET;
            legacy_mode_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SPREAD_LIMIT: spread_limit_reg <= cfg_data;
                REG_LEGACY_MODE:  legacy_mode_reg  <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Flow control: each stage moves when the stage after it has room.
    assign out_advance = !out_valid_reg || m_tready;
    assign in_advance  = !in_valid_reg || out_advance;
    assign s_tready    = in_advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_advance)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_advance && s_tvalid)
        begin
            gap_im_reg <= s_tdata[GAP_W-1:0];
            gap_mr_reg <= s_tdata[2*GAP_W-1:GAP_W];
            gap_rl_reg <= s_tdata[3*GAP_W-1:2*GAP_W];
        end
    end

    // Clip negative readings and widen the operands.
    assign gap_a = gap_clip(gap_im_reg);
    assign gap_b = gap_clip(gap_mr_reg);
    assign gap_c = gap_clip(gap_rl_reg);
    assign limit = calc_t'({{(CALC_W-LIMIT_W){1'b0}}, spread_limit_reg});

    fsd_legacy u_legacy (
        .gap_a  (gap_a),
        .gap_b  (gap_b),
        .gap_c  (gap_c),
        .limit  (limit),
        .angles (legacy_angles)
    );

    fsd_distribute u_distribute (
        .gap_a  (gap_a),
        .gap_b  (gap_b),
        .gap_c  (gap_c),
        .limit  (limit),
        .angles (dist_angles)
    );

    // Pick the mode and pack the angles at output width.
    assign sel_angles    = legacy_mode_reg ? legacy_angles : dist_angles;
    assign out_data_next = {sel_angles.little[ANG_W-1:0], sel_angles.ring[ANG_W-1:0],
                            sel_angles.middle[ANG_W-1:0], sel_angles.index[ANG_W-1:0]};

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_advance && in_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
